/* rtl/core/rmt_pkg.sv */
package rmt_pkg;

    // Defaults for the top-level parameters
    localparam int MUTEX_COUNT_DEF = 32;
    localparam int COUNT_BITS_DEF  = 16;
    localparam int PID_BITS_DEF    = 16;

    // Word field widths
    localparam int KIND_W = 3;
    localparam int ID_W   = 5;
    localparam int REQ_W  = 16;
    localparam int STAT_W = 3;
    localparam int IN_W   = KIND_W + ID_W + REQ_W;   // 24, already whole bytes
    localparam int OUT_W  = 16;                      // status, id, wake, padded

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_CREATE  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DESTROY = 3'd1;
    localparam logic [KIND_W-1:0] KIND_LOCK    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_TRYLOCK = 3'd3;
    localparam logic [KIND_W-1:0] KIND_UNLOCK  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 3'd5;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
    localparam logic [STAT_W-1:0] ST_INVALID = 3'd1;
    localparam logic [STAT_W-1:0] ST_BUSY    = 3'd2;
    localparam logic [STAT_W-1:0] ST_WAIT    = 3'd3;
    localparam logic [STAT_W-1:0] ST_PERM    = 3'd4;
    localparam logic [STAT_W-1:0] ST_FULL    = 3'd5;

    // Controller to datapath
    typedef struct packed {
        logic load;        // capture request, start entry read
        logic exec;        // apply single-entry op, emit its result
        logic walk_step;   // advance release walk, read next entry
        logic walk_touch;  // decrement walked entry, emit step result
        logic emit_final;  // emit closing result of a release
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic in_release;  // incoming word is a release request
        logic touched;     // walked entry is held by the requester
        logic walk_end;    // walk sits on the last entry
        logic out_free;    // output register can take a word this cycle
    } t_sts;

endpackage

/* rtl/core/rmt_ctrl.sv */
module rmt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  rmt_pkg::t_sts i_sts,
    output rmt_pkg::t_cmd o_cmd
);
    import rmt_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_WALK  = 2'd2;
    localparam logic [1:0] S_FINAL = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_sts.in_release ? S_WALK : S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_WALK: begin
                // a held entry needs an output slot before the walk moves on
                if (!i_sts.touched || i_sts.out_free) begin
                    o_cmd.walk_touch = i_sts.touched;
                    o_cmd.walk_step  = 1'b1;
                    if (i_sts.walk_end) begin
                        n_state = S_FINAL;
                    end
                end
            end
            S_FINAL: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_final = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_one_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.load, o_cmd.exec, o_cmd.walk_touch, o_cmd.emit_final}))
        else $error("more than one datapath action in a cycle");

    a_emit_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.exec || o_cmd.walk_touch || o_cmd.emit_final) |-> i_sts.out_free)
        else $error("result emitted into a busy output register");

    a_final_after_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == S_FINAL) |-> $past(r_state) == S_WALK)
        else $error("closing release result without a walk");

endmodule

/* rtl/core/rmt_datapath.sv */
module rmt_datapath #(
    parameter int MUTEX_COUNT = rmt_pkg::MUTEX_COUNT_DEF,
    parameter int COUNT_BITS  = rmt_pkg::COUNT_BITS_DEF,
    parameter int PID_BITS    = rmt_pkg::PID_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [rmt_pkg::IN_W-1:0]   i_in_data,
    input  rmt_pkg::t_cmd              i_cmd,
    output rmt_pkg::t_sts              o_sts,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [rmt_pkg::OUT_W-1:0]  o_out_data,
    output logic                       o_out_last
);
    import rmt_pkg::*;

    localparam int IDX_W = $clog2(MUTEX_COUNT);
    localparam int NF_W  = $clog2(MUTEX_COUNT + 1);
    localparam int ENT_W = 1 + COUNT_BITS + PID_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);
    localparam logic [IDX_W-1:0]      LAST_IDX  = IDX_W'(MUTEX_COUNT - 1);
    localparam logic [NF_W-1:0]       NF_FULL   = NF_W'(MUTEX_COUNT);
    localparam logic [NF_W-1:0]       NF_RESET  = NF_W'(1);

    // entry word: {valid, count, holder}
    logic [ENT_W-1:0]      r_mem [MUTEX_COUNT];
    logic [ENT_W-1:0]      r_rd;
    logic [KIND_W-1:0]     r_kind;
    logic [ID_W-1:0]       r_id;
    logic [PID_BITS-1:0]   r_req;
    logic [IDX_W-1:0]      r_idx;
    logic [NF_W-1:0]       r_next;
    logic                  r_out_valid;
    logic [STAT_W-1:0]     r_out_st;
    logic [ID_W-1:0]       r_out_id;
    logic                  r_out_wake;
    logic                  r_out_last;

    logic [KIND_W-1:0]     in_kind;
    logic [31:0]           in_id_ext;
    logic [31:0]           in_req_ext;
    logic [31:0]           id_ext;
    logic [31:0]           idx_ext;
    logic [31:0]           next_ext;
    logic [IDX_W-1:0]      id_addr;
    logic                  rd_valid;
    logic [COUNT_BITS-1:0] rd_cnt;
    logic [PID_BITS-1:0]   rd_hold;
    logic                  ok_id;
    logic                  idx_live;

    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;
    logic                  mem_we;
    logic [IDX_W-1:0]      wr_addr;
    logic [ENT_W-1:0]      wr_data;

    logic [STAT_W-1:0]     ex_st;
    logic [ID_W-1:0]       ex_id;
    logic                  ex_wake;
    logic                  ex_wr;
    logic [IDX_W-1:0]      ex_addr;
    logic [ENT_W-1:0]      ex_data;
    logic                  ex_inc;

    assign in_kind    = i_in_data[KIND_W-1:0];
    assign in_id_ext  = {{(32-ID_W){1'b0}}, i_in_data[KIND_W +: ID_W]};
    assign in_req_ext = {{(32-REQ_W){1'b0}}, i_in_data[KIND_W+ID_W +: REQ_W]};
    assign id_ext     = {{(32-ID_W){1'b0}}, r_id};
    assign idx_ext    = 32'(r_idx);
    assign next_ext   = 32'(r_next);
    assign id_addr    = id_ext[IDX_W-1:0];

    assign rd_valid = r_rd[ENT_W-1];
    assign rd_cnt   = r_rd[PID_BITS +: COUNT_BITS];
    assign rd_hold  = r_rd[PID_BITS-1:0];

    // entry zero and entries at or above the fill count were never created:
    // both read as invalid
    assign ok_id    = (id_ext != 32'd0) && (id_ext < next_ext) && rd_valid;
    assign idx_live = (idx_ext != 32'd0) && (idx_ext < next_ext) && rd_valid;

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_idx + 1'b1;
        if (i_cmd.load) begin
            rd_en   = 1'b1;
            rd_addr = (in_kind == KIND_RELEASE) ? '0 : in_id_ext[IDX_W-1:0];
        end else if (i_cmd.walk_step && (r_idx != LAST_IDX)) begin
            rd_en = 1'b1;
        end
    end

    // single-entry ops
    always_comb begin
        ex_st   = ST_OK;
        ex_id   = '0;
        ex_wake = 1'b0;
        ex_wr   = 1'b0;
        ex_addr = id_addr;
        ex_data = r_rd;
        ex_inc  = 1'b0;
        case (r_kind)
            KIND_CREATE: begin
                if (r_next == NF_FULL) begin
                    ex_st = ST_FULL;
                end else begin
                    ex_wr   = 1'b1;
                    ex_addr = r_next[IDX_W-1:0];
                    ex_data = {1'b1, {COUNT_BITS{1'b0}}, {PID_BITS{1'b0}}};
                    ex_id   = next_ext[ID_W-1:0];
                    ex_inc  = 1'b1;
                end
            end
            KIND_DESTROY: begin
                if (!ok_id) begin
                    ex_st = ST_INVALID;
                end else if (rd_cnt != '0) begin
                    ex_st = ST_BUSY;
                end else begin
                    ex_wr   = 1'b1;
                    ex_data = {1'b0, rd_cnt, {PID_BITS{1'b0}}};
                end
            end
            KIND_LOCK, KIND_TRYLOCK: begin
                if (!ok_id) begin
                    ex_st = ST_INVALID;
                end else if ((rd_cnt != '0) && (rd_hold != r_req)) begin
                    ex_st = (r_kind == KIND_LOCK) ? ST_WAIT : ST_BUSY;
                end else if (rd_cnt == COUNT_MAX) begin
                    ex_st = ST_BUSY;
                end else begin
                    ex_wr   = 1'b1;
                    ex_data = {1'b1, rd_cnt + COUNT_ONE, r_req};
                end
            end
            KIND_UNLOCK: begin
                if (!ok_id) begin
                    ex_st = ST_INVALID;
                end else if (rd_cnt == '0) begin
                    ex_st = ST_OK;
                end else if (rd_hold != r_req) begin
                    ex_st = ST_PERM;
                end else begin
                    ex_wr   = 1'b1;
                    ex_data = {1'b1, rd_cnt - COUNT_ONE, rd_hold};
                    ex_wake = (rd_cnt == COUNT_ONE);
                end
            end
            default: begin
                ex_st = ST_INVALID;
            end
        endcase
    end

    always_comb begin
        if (i_cmd.walk_touch) begin
            mem_we  = 1'b1;
            wr_addr = r_idx;
            wr_data = {1'b1, rd_cnt - COUNT_ONE, rd_hold};
        end else begin
            mem_we  = i_cmd.exec && ex_wr;
            wr_addr = ex_addr;
            wr_data = ex_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= in_kind;
            r_id   <= i_in_data[KIND_W +: ID_W];
            r_req  <= in_req_ext[PID_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_next <= NF_RESET;
        end else begin
            if (i_cmd.load) begin
                r_idx <= '0;
            end else if (i_cmd.walk_step) begin
                r_idx <= (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;
            end
            if (i_cmd.exec && ex_inc) begin
                r_next <= r_next + 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.exec || i_cmd.walk_touch || i_cmd.emit_final) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_out_st   <= ex_st;
            r_out_id   <= ex_id;
            r_out_wake <= ex_wake;
            r_out_last <= 1'b1;
        end else if (i_cmd.walk_touch) begin
            r_out_st   <= ST_OK;
            r_out_id   <= idx_ext[ID_W-1:0];
            r_out_wake <= (rd_cnt == COUNT_ONE);
            r_out_last <= 1'b0;
        end else if (i_cmd.emit_final) begin
            r_out_st   <= ST_OK;
            r_out_id   <= '0;
            r_out_wake <= 1'b0;
            r_out_last <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_last  = r_out_last;
    assign o_out_data  = {{(OUT_W-STAT_W-ID_W-1){1'b0}}, r_out_wake, r_out_id, r_out_st};

    assign o_sts.in_release = (in_kind == KIND_RELEASE);
    assign o_sts.touched    = idx_live && (rd_cnt != '0) && (rd_hold == r_req);
    assign o_sts.walk_end   = (r_idx == LAST_IDX);
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_next != '0) && (r_next <= NF_FULL))
        else $error("fill count out of range");

    a_create_bumps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && (r_kind == KIND_CREATE) && (r_next != NF_FULL))
        |=> r_next == $past(r_next) + 1'b1)
        else $error("successful create did not advance the id");

    a_step_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_last) |-> (r_out_st == ST_OK))
        else $error("release step result with a failing status");

endmodule

/* rtl/core/recursive_mutex_table_core.sv */
// Recursive mutex table.
// Input stream (s_axis): one request word per handshake; tdata holds kind,
// mutex id and requester. Output stream (m_axis): result words; tdata holds
// status, result id and wake, tlast marks the final word of a request.
// Create, destroy, lock, trylock and unlock give exactly one word. Release
// gives one word per entry it decremented, in rising id order, then a
// closing word with tlast set.
// Timing: a single-entry request is accepted with its entry read, then
// read-modify-written; the result is on m_axis the cycle after. Release
// walks all MUTEX_COUNT entries, one per cycle unless a step result waits on
// m_axis; the next entry is read while the current one is written back. One
// request is worked at a time; s_axis_tready is high only between requests.
// The output register decouples the sides: a new request is taken while a
// result still waits, and when m_axis stalls the block holds its next result
// and waits. Reset empties the table and restarts ids at one; no clearing
// pass is run, entry zero and ids at or above the fill mark read as absent.
module recursive_mutex_table_core #(
    parameter int MUTEX_COUNT = rmt_pkg::MUTEX_COUNT_DEF,
    parameter int COUNT_BITS  = rmt_pkg::COUNT_BITS_DEF,
    parameter int PID_BITS    = rmt_pkg::PID_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    // [2:0] kind, [7:3] mutex_id, [23:8] requester
    input  logic [rmt_pkg::IN_W-1:0]  i_s_axis_tdata,
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    // [2:0] status, [7:3] result_id, [8] wake, [15:9] zero
    output logic [rmt_pkg::OUT_W-1:0] o_m_axis_tdata,
    output logic                      o_m_axis_tlast
);
    import rmt_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // sequencing: idle / execute / walk / closing word
    rmt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // entry memory, id fill count, walk index, output register
    rmt_datapath #(
        .MUTEX_COUNT (MUTEX_COUNT),
        .COUNT_BITS  (COUNT_BITS),
        .PID_BITS    (PID_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_s_axis_tdata),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_data  (o_m_axis_tdata),
        .o_out_last  (o_m_axis_tlast)
    );

endmodule
